// File: sv/mtte_pkg.sv
// Shared types, op codes and key tables for the multi-tap text entry block.
package mtte_pkg;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] key;
      logic [7:0] index;
   } req_type;

   typedef struct packed {
      logic [7:0] text_length;
      logic       candidate_valid;
      logic [7:0] cand_char;
      logic       upper_case;
      logic [7:0] read_data;
   } rsp_type;

   localparam logic [2:0] OP_KEY       = 3'd0;
   localparam logic [2:0] OP_SPACE     = 3'd1;
   localparam logic [2:0] OP_BACKSPACE = 3'd2;
   localparam logic [2:0] OP_CASE      = 3'd3;
   localparam logic [2:0] OP_ENTER     = 3'd4;
   localparam logic [2:0] OP_READ      = 3'd5;

   localparam logic [3:0] NO_KEY    = 4'd15;
   localparam logic [3:0] KEY_SPACE = 4'd9;
   localparam logic [3:0] KEY_MAX   = 4'd9;

   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Character for a key at a given tap position; uppercase table when upper is set.
   function automatic logic [7:0] key_char(input logic upper, input logic [3:0] key,
                                           input logic [1:0] tap);
      logic [7:0] base;
      logic [7:0] ch;
      base = upper ? 8'h41 : 8'h61;
      ch   = CHAR_SPACE;
      case (key)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
            ch = base + 8'(key) * 8'd3 + 8'(tap);
         end
         4'd8: begin
            case (tap)
               2'd0:    ch = base + 8'd24;
               2'd1:    ch = base + 8'd25;
               default: ch = 8'h2e;
            endcase
         end
         default: ch = CHAR_SPACE;
      endcase
      return ch;
   endfunction

endpackage

// File: sv/multi_tap_text_entry.sv
// Multi-tap keypad text entry: candidate control, text memory and result pipeline.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_word (op, key, index)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_word (length, candidate, case, data)
//
// One word is accepted per cycle unless req stalls; its result passes the memory
// read register, then the output register. A space that both commits a candidate
// and appends a space needs two writes on the single memory write port; req stalls.
// Reset is synchronous and clears control state only; the text memory needs no
// clearing since only entries below the length are ever read.
// A stalled result holds the pipeline; req stalls once both stages are full and the result is stalled.
module multi_tap_text_entry
   import mtte_pkg::*;
#(
   parameter int TEXT_DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int AW = $clog2(TEXT_DEPTH);
   localparam logic [7:0] TEXT_CAP = 8'((TEXT_DEPTH - 1) < 255 ? (TEXT_DEPTH - 1) : 255);

   logic [7:0]    mem [TEXT_DEPTH];
   logic [7:0]    rdata_ff;

   logic [7:0]    length_ff, length_in;
   logic [3:0]    prev_key_ff, prev_key_in;
   logic [1:0]    tap_ff, tap_in;
   logic          pend_ff, pend_in;
   logic [7:0]    pend_char_ff, pend_char_in;
   logic          upper_ff, upper_in;

   logic          sp_ff, sp_in;
   logic [AW-1:0] sp_addr_ff, sp_addr_in;

   logic          s1_valid_ff;
   rsp_type       s1_word_ff, s1_word_in;
   logic          s1_hit_ff, s1_hit_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_word_ff, rsp_word_in;

   logic          in_acc;
   logic          s1_move;
   logic          commit_wr;
   logic [7:0]    len_c;
   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic          re;
   logic [AW-1:0] raddr;
   logic [1:0]    tap_step;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = sp_ff || (s1_valid_ff && rsp_valid_ff && rsp_stall);
   assign in_acc    = req_valid && !req_stall;

   assign commit_wr = pend_ff && (length_ff < TEXT_CAP);
   assign len_c     = commit_wr ? length_ff + 8'd1 : length_ff;
   assign tap_step  = (req_word.key == KEY_SPACE || tap_ff == 2'd2) ? 2'd0 : tap_ff + 2'd1;

   assign s1_hit_in = (req_word.op == OP_READ) && (req_word.index < length_ff);
   assign re        = in_acc && s1_hit_in;
   assign raddr     = AW'(req_word.index);

   always_comb begin
      length_in    = length_ff;
      prev_key_in  = prev_key_ff;
      tap_in       = tap_ff;
      pend_in      = pend_ff;
      pend_char_in = pend_char_ff;
      upper_in     = upper_ff;
      sp_in        = 1'b0;
      sp_addr_in   = sp_addr_ff;
      we           = 1'b0;
      waddr        = AW'(length_ff);
      wdata        = pend_char_ff;
      s1_word_in   = '0;

      // finish the second write of a space op
      if (sp_ff) begin
         we    = 1'b1;
         waddr = sp_addr_ff;
         wdata = CHAR_SPACE;
      end

      if (in_acc) begin
         case (req_word.op)
            OP_KEY: begin
               if (req_word.key <= KEY_MAX) begin
                  if (req_word.key == prev_key_ff) begin
                     tap_in = tap_step;
                  end else begin
                     we          = commit_wr;
                     length_in   = len_c;
                     prev_key_in = req_word.key;
                     tap_in      = 2'd0;
                  end
                  pend_in      = 1'b1;
                  pend_char_in = key_char(upper_ff, req_word.key, tap_in);
               end
            end
            OP_SPACE: begin
               pend_in      = 1'b0;
               pend_char_in = 8'd0;
               prev_key_in  = NO_KEY;
               tap_in       = 2'd0;
               length_in    = len_c;
               if (commit_wr) begin
                  we = 1'b1;
                  if (len_c < TEXT_CAP) begin
                     sp_in      = 1'b1;
                     sp_addr_in = AW'(len_c);
                     length_in  = len_c + 8'd1;
                  end
               end else if (len_c < TEXT_CAP) begin
                  we        = 1'b1;
                  waddr     = AW'(len_c);
                  wdata     = CHAR_SPACE;
                  length_in = len_c + 8'd1;
               end
            end
            OP_BACKSPACE: begin
               we           = commit_wr;
               pend_in      = 1'b0;
               pend_char_in = 8'd0;
               prev_key_in  = NO_KEY;
               tap_in       = 2'd0;
               length_in    = (len_c != 8'd0) ? len_c - 8'd1 : len_c;
            end
            OP_CASE: begin
               we           = commit_wr;
               pend_in      = 1'b0;
               pend_char_in = 8'd0;
               prev_key_in  = NO_KEY;
               tap_in       = 2'd0;
               length_in    = len_c;
               upper_in     = !upper_ff;
            end
            OP_ENTER: begin
               // committed text is discarded right away, so skip the write
               pend_in      = 1'b0;
               pend_char_in = 8'd0;
               prev_key_in  = NO_KEY;
               tap_in       = 2'd0;
               length_in    = 8'd0;
               upper_in     = 1'b0;
            end
            default: begin
            end
         endcase

         s1_word_in.text_length     = (req_word.op == OP_ENTER) ? len_c : length_in;
         s1_word_in.candidate_valid = pend_in;
         s1_word_in.cand_char       = pend_char_in;
         s1_word_in.upper_case      = upper_in;
      end
   end

   always_comb begin
      rsp_word_in           = s1_word_ff;
      rsp_word_in.read_data = s1_hit_ff ? rdata_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= 8'd0;
         prev_key_ff  <= NO_KEY;
         tap_ff       <= 2'd0;
         pend_ff      <= 1'b0;
         pend_char_ff <= 8'd0;
         upper_ff     <= 1'b0;
         sp_ff        <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         prev_key_ff  <= prev_key_in;
         tap_ff       <= tap_in;
         pend_ff      <= pend_in;
         pend_char_ff <= pend_char_in;
         upper_ff     <= upper_in;
         sp_ff        <= sp_in;
         if (in_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sp_addr_ff <= sp_addr_in;
      if (in_acc) begin
         s1_word_ff <= s1_word_in;
         s1_hit_ff  <= s1_hit_in;
      end
      if (s1_move) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_sp_after_space: assert property (@(posedge clock) disable iff (reset)
      sp_ff |-> $past(in_acc && req_word.op == OP_SPACE))
      else $error("deferred space write without an accepted space word");

   a_idle_no_key: assert property (@(posedge clock) disable iff (reset)
      !pend_ff |-> (prev_key_ff == NO_KEY && tap_ff == 2'd0 && pend_char_ff == 8'd0))
      else $error("key state left behind with no candidate");

   a_enter_clears: assert property (@(posedge clock) disable iff (reset)
      (in_acc && req_word.op == OP_ENTER) |=> (length_ff == 8'd0 && !upper_ff && !pend_ff))
      else $error("enter did not clear the entry state");

   a_length_cap: assert property (@(posedge clock) disable iff (reset)
      (in_acc && req_word.op == OP_SPACE) |=> (length_ff <= TEXT_CAP))
      else $error("length passed the text capacity");

endmodule
